// ===== hw/rtl/integer_to_ascii_radix_macros.svh =====
// assertion helpers shared by the rtl
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

// same-cycle implication
`define I2A_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2a assertion failed");

// next-cycle implication
`define I2A_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2a assertion failed");

`endif

// ===== hw/rtl/i2a_pkg.sv =====
package i2a_pkg;

    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_ALPHA = 8'd55;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    localparam logic REG_RADIX = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctl_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_TEN)
        begin
            return ext + ASCII_ZERO;
        end
        return ext + ASCII_ALPHA;
    endfunction

endpackage

// ===== hw/rtl/i2a_cell.sv =====
module i2a_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [i2a_pkg::DIGIT_W-1:0] radix,
    input  i2a_pkg::cell_ctl_t          ctl,
    input  logic                        en_in,
    input  logic                        carry_in,
    input  logic [i2a_pkg::DIGIT_W-1:0] digit_in,
    output logic                        en_out,
    output logic                        carry_out,
    output logic [i2a_pkg::DIGIT_W-1:0] digit
);
    import i2a_pkg::*;

    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               en_reg;
    logic               carry_reg, carry_next;
    logic [DIGIT_W:0]   dbl;

    // doubled digit plus incoming bit, folded back below the radix
    always_comb
    begin
        dbl = {digit_reg, carry_in};
        if (dbl >= {1'b0, radix})
        begin
            carry_next = 1'b1;
            digit_next = DIGIT_W'(dbl - {1'b0, radix});
        end
        else
        begin
            carry_next = 1'b0;
            digit_next = dbl[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
            en_reg    <= 1'b0;
            carry_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            digit_reg <= '0;
            en_reg    <= 1'b0;
            carry_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            digit_reg <= digit_in;
        end
        else
        begin
            en_reg <= en_in;
            if (en_in)
            begin
                digit_reg <= digit_next;
                carry_reg <= carry_next;
            end
        end
    end

    assign en_out    = en_reg;
    assign carry_out = carry_reg;
    assign digit     = digit_reg;

endmodule

// ===== hw/rtl/integer_to_ascii_radix.sv =====
// requests: a value is accepted only while idle, i.e. once the previous value's last character
//   has been registered for output; leading zero digit positions are skipped without output
// negative values add a leading minus character
// conversion: bits enter the digit cell chain one per cycle while the carry wavefront
//   ripples through the cells; readout visits one digit position per cycle unless the sink stalls
// reset: radix returns to 10, cell chain, sequencer and output register cleared
module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [i2a_pkg::PADDR_W-1:0] paddr,
    input  logic [i2a_pkg::PDATA_W-1:0] pwdata,
    output logic [i2a_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic [i2a_pkg::CHAR_W-1:0]  character,
    output logic                        last_char,
    output logic                        out_valid,
    input  logic                        out_ready
);
    import i2a_pkg::*;

    `include "integer_to_ascii_radix_macros.svh"

    localparam int N     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(2 * N);

    logic [DIGIT_W-1:0] radix_reg;
    logic [DIGIT_W-1:0] eff_radix;
    logic               reg_sel;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [N-1:0]       mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic               seen_reg, seen_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  character_reg, character_next;
    logic               last_char_reg, last_char_next;

    logic               in_acc;
    logic               out_free;
    logic               last_pos;
    logic               feed;
    cell_ctl_t          ctl;

    logic               en    [0:N];
    logic               carry [0:N];
    logic [DIGIT_W-1:0] dig   [0:N-1];
    logic [DIGIT_W-1:0] dig_in [0:N-1];

    // config register
    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (psel && penable && pwrite && (reg_sel == REG_RADIX))
        begin
            radix_reg <= pwdata[DIGIT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_RADIX)
        begin
            prdata = {{(PDATA_W-DIGIT_W){1'b0}}, radix_reg};
        end
    end

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            eff_radix = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            eff_radix = RADIX_MAX;
        end
        else
        begin
            eff_radix = radix_reg;
        end
    end

    // digit cell chain, least significant digit in cell 0
    assign en[0]    = feed;
    assign carry[0] = mag_reg[N-1];

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign dig_in[gi] = '0;
            end
            else
            begin : g_rest
                assign dig_in[gi] = dig[gi-1];
            end

            i2a_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .radix     (eff_radix),
                .ctl       (ctl),
                .en_in     (en[gi]),
                .carry_in  (carry[gi]),
                .digit_in  (dig_in[gi]),
                .en_out    (en[gi+1]),
                .carry_out (carry[gi+1]),
                .digit     (dig[gi])
            );
        end
    endgenerate

    // sequencer
    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign last_pos = (cnt_reg == CNT_W'(N - 1));
    assign feed     = (state_reg == ST_CONV) && (cnt_reg < CNT_W'(N));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        seen_next      = seen_reg;
        character_next = character_reg;
        last_char_next = last_char_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        ctl            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    ctl.clear  = 1'b1;
                    neg_next   = value[N-1];
                    mag_next   = value[N-1] ? (~value + N'(1)) : value;
                    cnt_next   = '0;
                    seen_next  = 1'b0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                mag_next = {mag_reg[N-2:0], 1'b0};
                if (cnt_reg == CNT_W'(2 * N - 2))
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (neg_reg)
                    begin
                        neg_next       = 1'b0;
                        character_next = ASCII_MINUS;
                        last_char_next = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    else if ((dig[N-1] == '0) && !seen_reg && !last_pos)
                    begin
                        ctl.shift = 1'b1;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ctl.shift      = 1'b1;
                        cnt_next       = cnt_reg + CNT_W'(1);
                        seen_next      = 1'b1;
                        character_next = digit_char(dig[N-1]);
                        last_char_next = last_pos;
                        out_valid_next = 1'b1;
                        if (last_pos)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            character_reg <= '0;
            last_char_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            neg_reg       <= neg_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            character_reg <= character_next;
            last_char_reg <= last_char_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
    end

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last_char = last_char_reg;

    `I2A_ASSERT_NOW(a_top_no_carry, 1'b1, !carry[N])
    `I2A_ASSERT_NOW(a_chain_busy_only_in_conv, en[1], state_reg == ST_CONV)
    `I2A_ASSERT_NEXT(a_request_starts_conv, in_valid && in_ready, state_reg == ST_CONV)
    `I2A_ASSERT_NOW(a_minus_never_last, out_valid && (character == ASCII_MINUS), !last_char)

endmodule

// ===== test/integer_to_ascii_radix_tb.sv =====
`timescale 1ns / 1ps

module integer_to_ascii_radix_tb;

    import i2a_pkg::*;

    localparam int VALUE_W = 32;
    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 3 * VALUE_W + 2;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_VALUES = 36;
    localparam int MAX_PRINTED = 40;

    localparam logic [PADDR_W-1:0] RADIX_ADDR = PADDR_W'(4 * REG_RADIX);
    localparam logic [DIGIT_W-1:0] DEFAULT_RADIX = 6'd10;
    localparam logic [DIGIT_W-1:0] LOWEST_RADIX = 6'd2;
    localparam logic [DIGIT_W-1:0] HIGHEST_RADIX = 6'd36;
    localparam logic [CHAR_W-1:0] CODE_ZERO = "0";
    localparam logic [CHAR_W-1:0] CODE_LETTER_BASE = 8'd55;
    localparam logic [CHAR_W-1:0] CODE_MINUS = "-";
    localparam logic [VALUE_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] MOST_POSITIVE = 32'h7fff_ffff;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic signed [VALUE_W-1:0] value = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CHAR_W-1:0] character;
    logic last_char;
    logic out_valid;
    logic out_ready = 1'b0;

    text_char_t expected_text[$];
    logic [DIGIT_W-1:0] model_radix = DEFAULT_RADIX;
    int mismatches = 0;
    int values_sent = 0;
    int chars_checked = 0;
    int radix_writes = 0;
    int burst_left = 0;
    int cycle_count = 0;
    logic hold_request = 1'b0;
    int hold_left = 0;
    logic [15:0] sink_pattern = '1;
    logic [3:0] sink_phase = '0;

    integer_to_ascii_radix #(
        .VALUE_WIDTH(VALUE_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .value(value),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .character(character),
        .last_char(last_char),
        .out_valid(out_valid),
        .out_ready(out_ready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, expected_text.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
        begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    // expected text of one value under the current radix
    function automatic void spell_value(input logic [VALUE_W-1:0] v);
        logic [DIGIT_W-1:0] base;
        logic [VALUE_W-1:0] mag;
        logic [DIGIT_W-1:0] digits[VALUE_W];
        int n;
        text_char_t c;
        if (model_radix < LOWEST_RADIX)
        begin
            base = LOWEST_RADIX;
        end
        else if (model_radix > HIGHEST_RADIX)
        begin
            base = HIGHEST_RADIX;
        end
        else
        begin
            base = model_radix;
        end
        mag = v[VALUE_W-1] ? -v : v;
        if (mag == '0)
        begin
            c.code = CODE_ZERO;
            c.last = 1'b1;
            expected_text.push_back(c);
            return;
        end
        n = 0;
        while (mag != '0)
        begin
            digits[n] = DIGIT_W'(mag % base);
            mag = mag / base;
            n++;
        end
        if (v[VALUE_W-1])
        begin
            c.code = CODE_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            if (digits[i] < 10)
            begin
                c.code = CODE_ZERO + CHAR_W'(digits[i]);
            end
            else
            begin
                c.code = CODE_LETTER_BASE + CHAR_W'(digits[i]);
            end
            c.last = (i == 0);
            expected_text.push_back(c);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_text.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                        character, last_char));
            end
            else
            begin
                if (character !== expected_text[0].code)
                begin
                    flag_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                            character, expected_text[0].code));
                end
                if (last_char !== expected_text[0].last)
                begin
                    flag_mismatch($sformatf("last_char %0b, expected %0b on 0x%02h",
                                            last_char, expected_text[0].last,
                                            expected_text[0].code));
                end
                void'(expected_text.pop_front());
                chars_checked++;
            end
        end
    end

    // sink: long hold on request, otherwise a rotating stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
            sink_phase = '0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            if (sink_phase == '0)
            begin
                case ($urandom_range(0, 3))
                    0: sink_pattern = '1;
                    1: sink_pattern = 16'($urandom);
                    2: sink_pattern = 16'($urandom | $urandom);
                    default: sink_pattern = 16'($urandom & $urandom);
                endcase
            end
            out_ready <= sink_pattern[sink_phase];
            sink_phase = sink_phase + 1'b1;
        end
    end

    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        value <= v;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        spell_value(v);
        values_sent++;
        burst_left--;
    endtask

    task automatic wait_for_text();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= RADIX_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        rdata = prdata;
        if (wr)
        begin
            model_radix = wdata[DIGIT_W-1:0];
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_radix_readback();
        logic [PDATA_W-1:0] rdata;
        apb_access(1'b0, '0, rdata);
        if (rdata[DIGIT_W-1:0] !== model_radix)
        begin
            flag_mismatch($sformatf("radix reads %0d, expected %0d",
                                    rdata[DIGIT_W-1:0], model_radix));
        end
    endtask

    // upper data bits are junk, only the low six land in the register
    task automatic set_radix(input logic [DIGIT_W-1:0] r);
        logic [PDATA_W-1:0] rdata;
        wait_for_text();
        apb_access(1'b1, {(PDATA_W-DIGIT_W)'($urandom), r}, rdata);
        radix_writes++;
        check_radix_readback();
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(input logic [DIGIT_W-1:0] r);
        longint p;
        longint b;
        int k;
        logic [VALUE_W-1:0] v;
        b = (r < LOWEST_RADIX) ? LOWEST_RADIX : (r > HIGHEST_RADIX) ? HIGHEST_RADIX : r;
        case ($urandom_range(0, 5))
            0:
            begin
                v = $urandom_range(0, 32'(2 * b));
            end
            1:
            begin
                // around a power of the base, where the digit count changes
                p = 1;
                k = $urandom_range(1, 31);
                while (k > 0 && p * b <= longint'(MOST_POSITIVE))
                begin
                    p = p * b;
                    k--;
                end
                v = VALUE_W'(p + $urandom_range(0, 2) - 1);
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = MOST_NEGATIVE;
                    1: v = MOST_POSITIVE;
                    2: v = '0;
                    default: v = '1;
                endcase
                return v;
            end
            3:
            begin
                v = $urandom >> $urandom_range(0, 31);
            end
            default:
            begin
                v = $urandom;
                return v;
            end
        endcase
        if ($urandom_range(0, 1))
        begin
            v = -v;
        end
        return v;
    endfunction

    task automatic test_reset_radix();
        check_radix_readback();
    endtask

    task automatic test_decimal_edges();
        send_value('0);
        send_value(32'd1);
        send_value('1);
        send_value(MOST_POSITIVE);
        send_value(MOST_NEGATIVE);
        send_value(32'd1234567890);
        send_value(-32'sd9);
    endtask

    task automatic test_binary_extremes();
        set_radix(LOWEST_RADIX);
        send_value(MOST_NEGATIVE);
        send_value(MOST_POSITIVE);
        send_value('1);
    endtask

    task automatic test_base36_letters();
        set_radix(HIGHEST_RADIX);
        send_value(32'd35);
        send_value(32'd370);
        send_value(-32'sd36);
        send_value(MOST_NEGATIVE);
        send_value(MOST_POSITIVE);
    endtask

    // out of range radix clamps to the nearest legal base
    task automatic test_radix_clamp();
        set_radix(6'd0);
        send_value(32'd5);
        set_radix(6'd1);
        send_value(-32'sd6);
        set_radix(6'd37);
        send_value(32'd36);
        set_radix(6'd63);
        send_value(32'd1295);
    endtask

    task automatic test_random_phases();
        logic [DIGIT_W-1:0] r;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                r = LOWEST_RADIX;
            end
            else if (ph == 1)
            begin
                r = HIGHEST_RADIX;
            end
            else if (ph == 2)
            begin
                r = DEFAULT_RADIX;
            end
            else
            begin
                r = $urandom_range(0, 63);
            end
            set_radix(r);
            for (int i = 0; i < PHASE_VALUES; i++)
            begin
                send_value(pick_value(r));
            end
        end
    endtask

    task automatic test_sink_hold();
        set_radix(LOWEST_RADIX);
        hold_request = 1'b1;
        for (int i = 0; i < 16; i++)
        begin
            send_value(pick_value(LOWEST_RADIX));
        end
        wait_for_text();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_radix();
        test_decimal_edges();
        test_binary_extremes();
        test_base36_letters();
        test_radix_clamp();
        test_random_phases();
        test_sink_hold();
        wait_for_text();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("converted %0d values into %0d characters across %0d radix writes",
                 values_sent, chars_checked, radix_writes);
        $display("bases two to thirty-six, clamped radix, extremes, long sink hold");
        if (mismatches == 0 && expected_text.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("%0d mismatches, %0d characters never seen",
                     mismatches, expected_text.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
